// File: design/bcsc_pkg.sv
package bcsc_pkg;

  localparam int DIV_W     = 32;
  localparam int CAL_WORDS = 11;
  localparam int CAL_IDX_W = 4;

  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_COMP = 1'b1;

  localparam logic [CAL_IDX_W-1:0] CAL_AC1 = 4'd0;
  localparam logic [CAL_IDX_W-1:0] CAL_AC2 = 4'd1;
  localparam logic [CAL_IDX_W-1:0] CAL_AC3 = 4'd2;
  localparam logic [CAL_IDX_W-1:0] CAL_AC4 = 4'd3;
  localparam logic [CAL_IDX_W-1:0] CAL_AC5 = 4'd4;
  localparam logic [CAL_IDX_W-1:0] CAL_AC6 = 4'd5;
  localparam logic [CAL_IDX_W-1:0] CAL_B1  = 4'd6;
  localparam logic [CAL_IDX_W-1:0] CAL_B2  = 4'd7;
  localparam logic [CAL_IDX_W-1:0] CAL_MC  = 4'd9;
  localparam logic [CAL_IDX_W-1:0] CAL_MD  = 4'd10;

  localparam logic signed [28:0] T_RND   = 29'sd8;
  localparam logic signed [15:0] T_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] T_MIN   = 16'sh8000;
  localparam logic signed [29:0] B6_OFS  = 30'sd4000;
  localparam logic [31:0]        B4_BIAS = 32'd32768;
  localparam logic [15:0]        B7_BASE = 16'd50000;
  localparam logic [11:0]        P_K1    = 12'd3038;
  localparam logic signed [13:0] P_K2    = -14'sd7357;
  localparam logic signed [44:0] P_K3    = 45'sd3791;
  localparam logic [17:0]        P_MAX   = 18'h3FFFF;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] b1;
    logic [15:0] b2;
  } cal_late_t;

endpackage

// File: design/bcsc_div.sv
module bcsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [bcsc_pkg::DIV_W-1:0] in_dvd,
  input  logic [bcsc_pkg::DIV_W-1:0] in_dvs,
  output logic                       out_vld,
  output logic [bcsc_pkg::DIV_W-1:0] out_quo
);
  import bcsc_pkg::*;

  logic             vld_r   [DIV_W];
  logic [DIV_W-1:0] acc_r   [DIV_W];
  logic [DIV_W-1:0] rem_r   [DIV_W];
  logic [DIV_W-1:0] dvs_r   [DIV_W];
  logic [DIV_W-1:0] acc_in  [DIV_W];
  logic [DIV_W-1:0] rem_in  [DIV_W];
  logic [DIV_W-1:0] dvs_in  [DIV_W];
  logic [DIV_W-1:0] acc_nxt [DIV_W];
  logic [DIV_W-1:0] rem_nxt [DIV_W];
  logic [DIV_W:0]   trial   [DIV_W];
  logic [DIV_W-1:0] ge;

  // one quotient bit per stage, restoring
  always_comb begin
    acc_in[0] = in_dvd;
    rem_in[0] = '0;
    dvs_in[0] = in_dvs;
    for (int k = 1; k < DIV_W; k++) begin
      acc_in[k] = acc_r[k-1];
      rem_in[k] = rem_r[k-1];
      dvs_in[k] = dvs_r[k-1];
    end
    for (int k = 0; k < DIV_W; k++) begin
      trial[k]   = {rem_in[k], acc_in[k][DIV_W-1]};
      ge[k]      = trial[k] >= {1'b0, dvs_in[k]};
      rem_nxt[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, dvs_in[k]}) : trial[k][DIV_W-1:0];
      acc_nxt[k] = {acc_in[k][DIV_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_W; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < DIV_W; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_W; k++) begin
      acc_r[k] <= acc_nxt[k];
      rem_r[k] <= rem_nxt[k];
      dvs_r[k] <= dvs_in[k];
    end
  end

  assign out_vld = vld_r[DIV_W-1];
  assign out_quo = acc_r[DIV_W-1];

endmodule

// File: design/barometric_sensor_compensation_unit.sv
// readings run stages a-d, temp divider, stages e-n, pressure divider, then o, p, u, out
// throughput: one transaction per cycle, busy stays low; calibration writes give no result
// the two 32-stage divider pipelines set most of the latency
// the receiver cannot stall, each result is shown for exactly one cycle
// synchronous active-low reset clears valid bits and oversampling mode
// calibration words are undefined until written
module barometric_sensor_compensation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [3:0]         in_calib_index,
  input  logic [15:0]        in_calib_value,
  input  logic [15:0]        in_raw_temperature,
  input  logic [18:0]        in_raw_pressure,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  output logic               out_valid,
  output logic signed [15:0] out_temperature_tenths,
  output logic [17:0]        out_pressure_pa,
  output logic               out_divide_fault
);
  import bcsc_pkg::*;

  typedef struct packed {
    logic [18:0] x1;
    logic        neg;
    logic        dz;
    cal_late_t   late;
    logic [18:0] up;
  } side1_t;

  typedef struct packed {
    logic [15:0] t;
    logic        dz;
    logic        bz;
    logic        big;
  } side2_t;

  logic        acc;
  logic [1:0]  oss_r;
  logic [15:0] cal_r [CAL_WORDS];
  cal_late_t   late_now;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r <= '0;
    end else if (cfg_wr_en) begin
      oss_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_operation == OP_CAL && in_calib_index < CAL_IDX_W'(CAL_WORDS)) begin
      cal_r[in_calib_index] <= in_calib_value;
    end
  end

  assign late_now.ac1 = cal_r[CAL_AC1];
  assign late_now.ac2 = cal_r[CAL_AC2];
  assign late_now.ac3 = cal_r[CAL_AC3];
  assign late_now.ac4 = cal_r[CAL_AC4];
  assign late_now.b1  = cal_r[CAL_B1];
  assign late_now.b2  = cal_r[CAL_B2];

  // valid bits
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r;
  logic i_vld_r, j_vld_r, k_vld_r, l_vld_r, m_vld_r, n_vld_r, o_vld_r, p_vld_r;
  logic u_vld_r, out_valid_r;
  logic div1_vld, div2_vld;

  // stage a
  logic [15:0] a_ut_r, a_ac5_r, a_ac6_r, a_mc_r, a_md_r;
  logic [18:0] a_up_r;
  cal_late_t   a_late_r;

  // stage b
  logic signed [16:0] b_diff;
  logic signed [33:0] b_prod_nxt, b_prod_r;
  logic [15:0]        b_mc_r, b_md_r;
  logic [18:0]        b_up_r;
  cal_late_t          b_late_r;

  always_comb begin
    b_diff     = $signed({1'b0, a_ut_r}) - $signed({1'b0, a_ac6_r});
    b_prod_nxt = 34'(b_diff) * 34'($signed({1'b0, a_ac5_r}));
  end

  // stage c
  logic signed [18:0] c_x1_nxt, c_x1_r;
  logic signed [19:0] c_div_nxt, c_div_r;
  logic [15:0]        c_mc_r;
  logic [18:0]        c_up_r;
  cal_late_t          c_late_r;

  always_comb begin
    c_x1_nxt  = 19'(b_prod_r >>> 15);
    c_div_nxt = 20'(c_x1_nxt) + 20'($signed(b_md_r));
  end

  // stage d
  logic signed [16:0] d_mcx;
  logic [16:0]        d_mc_mag;
  logic [19:0]        d_div_mag;
  logic [DIV_W-1:0]   d_dvd_nxt, d_dvs_nxt, d_dvd_r, d_dvs_r;
  logic [18:0]        d_x1_r;
  logic               d_neg_r, d_dz_r;
  logic [18:0]        d_up_r;
  cal_late_t          d_late_r;

  always_comb begin
    d_mcx     = $signed({c_mc_r[15], c_mc_r});
    d_mc_mag  = d_mcx[16] ? 17'(-d_mcx) : 17'(d_mcx);
    d_div_mag = c_div_r[19] ? 20'(-c_div_r) : 20'(c_div_r);
    d_dvd_nxt = DIV_W'({d_mc_mag, 11'b0});
    d_dvs_nxt = DIV_W'(d_div_mag);
  end

  // temperature divider
  logic [DIV_W-1:0] q1;
  side1_t           side1_in;
  side1_t           side1_r [DIV_W];
  side1_t           s1o;

  bcsc_div u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld_r),
    .in_dvd  (d_dvd_r),
    .in_dvs  (d_dvs_r),
    .out_vld (div1_vld),
    .out_quo (q1)
  );

  assign side1_in = '{x1: d_x1_r, neg: d_neg_r, dz: d_dz_r, late: d_late_r, up: d_up_r};
  assign s1o      = side1_r[DIV_W-1];

  // stage e
  logic [27:0]        e_qmag;
  logic signed [27:0] e_x2;
  logic signed [28:0] e_b5_nxt, e_b5_r;
  logic               e_dz_r;
  logic [18:0]        e_up_r;
  cal_late_t          e_late_r;

  always_comb begin
    e_qmag   = {1'b0, q1[26:0]};
    e_x2     = s1o.neg ? -$signed(e_qmag) : $signed(e_qmag);
    e_b5_nxt = 29'($signed(s1o.x1)) + 29'(e_x2);
  end

  // stage f
  logic signed [28:0] f_tsum;
  logic signed [24:0] f_traw;
  logic [15:0]        f_t_nxt, f_t_r;
  logic signed [29:0] f_b6_nxt, f_b6_r;
  logic               f_dz_r;
  logic [18:0]        f_up_r;
  cal_late_t          f_late_r;

  always_comb begin
    f_tsum = e_b5_r + T_RND;
    f_traw = 25'(f_tsum >>> 4);
    if (f_traw > 25'(T_MAX)) begin
      f_t_nxt = T_MAX;
    end else if (f_traw < 25'(T_MIN)) begin
      f_t_nxt = T_MIN;
    end else begin
      f_t_nxt = f_traw[15:0];
    end
    f_b6_nxt = 30'(e_b5_r) - B6_OFS;
  end

  // stage g
  logic signed [59:0] g_sq_nxt, g_sq_r;
  logic signed [45:0] g_m2_nxt, g_m2_r, g_m3_nxt, g_m3_r;
  logic [15:0]        g_t_r;
  logic               g_dz_r;
  logic [18:0]        g_up_r;
  cal_late_t          g_late_r;

  always_comb begin
    g_sq_nxt = 60'(f_b6_r) * 60'(f_b6_r);
    g_m2_nxt = 46'($signed(f_late_r.ac2)) * 46'(f_b6_r);
    g_m3_nxt = 46'($signed(f_late_r.ac3)) * 46'(f_b6_r);
  end

  // stage h: b6 squared split in two halves
  logic [47:0]        h_sq12;
  logic signed [40:0] h_b2lo_nxt, h_b2hi_nxt, h_b1lo_nxt, h_b1hi_nxt;
  logic signed [40:0] h_b2lo_r, h_b2hi_r, h_b1lo_r, h_b1hi_r;
  logic signed [34:0] h_x2a_nxt, h_x2a_r;
  logic signed [32:0] h_x1b_nxt, h_x1b_r;
  logic [15:0]        h_t_r;
  logic               h_dz_r;
  logic [18:0]        h_up_r;
  cal_late_t          h_late_r;

  always_comb begin
    h_sq12     = g_sq_r[59:12];
    h_b2lo_nxt = 41'($signed(g_late_r.b2)) * 41'($signed({1'b0, h_sq12[23:0]}));
    h_b2hi_nxt = 41'($signed(g_late_r.b2)) * 41'($signed({1'b0, h_sq12[47:24]}));
    h_b1lo_nxt = 41'($signed(g_late_r.b1)) * 41'($signed({1'b0, h_sq12[23:0]}));
    h_b1hi_nxt = 41'($signed(g_late_r.b1)) * 41'($signed({1'b0, h_sq12[47:24]}));
    h_x2a_nxt  = 35'(g_m2_r >>> 11);
    h_x1b_nxt  = 33'(g_m3_r >>> 13);
  end

  // stage i
  logic signed [65:0] i_b2sq_nxt, i_b2sq_r, i_b1sq_nxt, i_b1sq_r;
  logic signed [34:0] i_x2a_r;
  logic signed [32:0] i_x1b_r;
  logic [15:0]        i_t_r;
  logic               i_dz_r;
  logic [18:0]        i_up_r;
  cal_late_t          i_late_r;

  always_comb begin
    i_b2sq_nxt = (66'(h_b2hi_r) <<< 24) + 66'(h_b2lo_r);
    i_b1sq_nxt = (66'(h_b1hi_r) <<< 24) + 66'(h_b1lo_r);
  end

  // stage j
  logic signed [55:0] j_x3a_nxt, j_x3a_r;
  logic signed [50:0] j_s_nxt, j_s_r;
  logic [15:0]        j_t_r;
  logic               j_dz_r;
  logic [18:0]        j_up_r;
  cal_late_t          j_late_r;

  always_comb begin
    j_x3a_nxt = 56'(i_b2sq_r >>> 11) + 56'(i_x2a_r);
    j_s_nxt   = 51'(i_x1b_r) + 51'(i_b1sq_r >>> 16) + 51'sd2;
  end

  // stage k
  logic signed [59:0] k_base, k_v_nxt, k_v_r;
  logic [31:0]        k_lo_nxt, k_lo_r;
  logic signed [50:0] k_x3;
  logic [15:0]        k_t_r;
  logic               k_dz_r;
  logic [18:0]        k_up_r;
  cal_late_t          k_late_r;

  always_comb begin
    k_base   = (60'($signed(j_late_r.ac1)) <<< 2) + 60'(j_x3a_r);
    k_v_nxt  = k_base <<< oss_r;
    k_x3     = j_s_r >>> 2;
    k_lo_nxt = k_x3[31:0] + B4_BIAS;
  end

  // stage l
  logic signed [60:0] l_w, l_wc, l_wq;
  logic [47:0]        l_prod;
  logic [31:0]        l_b3_nxt, l_b3_r;
  logic [16:0]        l_b4_nxt, l_b4_r;
  logic [15:0]        l_t_r;
  logic               l_dz_r;
  logic [18:0]        l_up_r;

  always_comb begin
    l_w      = 61'(k_v_r) + 61'sd2;
    l_wc     = l_w + (l_w[60] ? 61'sd3 : 61'sd0);
    l_wq     = l_wc >>> 2;
    l_b3_nxt = l_wq[31:0];
    l_prod   = 48'(k_late_r.ac4) * 48'(k_lo_r);
    l_b4_nxt = l_prod[31:15];
  end

  // stage m
  logic [31:0] m_diff_nxt, m_diff_r;
  logic [16:0] m_b4_r;
  logic [15:0] m_t_r;
  logic        m_dz_r;

  assign m_diff_nxt = 32'(l_up_r) - l_b3_r;

  // stage n
  logic [15:0] n_fac;
  logic [47:0] n_prod;
  logic [31:0] n_b7_nxt, n_b7_r;
  logic [16:0] n_b4_r;
  logic [15:0] n_t_r;
  logic        n_dz_r;

  always_comb begin
    n_fac    = B7_BASE >> oss_r;
    n_prod   = 48'(m_diff_r) * 48'(n_fac);
    n_b7_nxt = n_prod[31:0];
  end

  // pressure divider
  logic [DIV_W-1:0] div2_dvd, div2_dvs, q2;
  side2_t           side2_in;
  side2_t           side2_r [DIV_W];
  side2_t           s2o;

  assign div2_dvd = n_b7_r[31] ? n_b7_r : {n_b7_r[30:0], 1'b0};
  assign div2_dvs = DIV_W'(n_b4_r);
  assign side2_in = '{t: n_t_r, dz: n_dz_r, bz: (n_b4_r == '0), big: n_b7_r[31]};
  assign s2o      = side2_r[DIV_W-1];

  bcsc_div u_div_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (n_vld_r),
    .in_dvd  (div2_dvd),
    .in_dvs  (div2_dvs),
    .out_vld (div2_vld),
    .out_quo (q2)
  );

  always_ff @(posedge clk) begin
    side1_r[0] <= side1_in;
    side2_r[0] <= side2_in;
    for (int k = 1; k < DIV_W; k++) begin
      side1_r[k] <= side1_r[k-1];
      side2_r[k] <= side2_r[k-1];
    end
  end

  // stage o
  logic [31:0] o_p_nxt, o_p_r;
  logic [15:0] o_t_r;
  logic        o_dz_r, o_bz_r;

  assign o_p_nxt = s2o.big ? {q2[30:0], 1'b0} : q2;

  // stage p
  logic [23:0]        p_ps;
  logic [47:0]        p_sq_nxt, p_sq_r;
  logic signed [46:0] p_m_nxt, p_m_r;
  logic [31:0]        p_p_r;
  logic [15:0]        p_t_r;
  logic               p_dz_r, p_bz_r;

  always_comb begin
    p_ps     = o_p_r[31:8];
    p_sq_nxt = 48'(p_ps) * 48'(p_ps);
    p_m_nxt  = 47'(P_K2) * 47'($signed({1'b0, o_p_r}));
  end

  // stage u
  logic [59:0]        u_prod;
  logic [43:0]        u_x1_nxt, u_x1_r;
  logic signed [30:0] u_x2_nxt, u_x2_r;
  logic [31:0]        u_p_r;
  logic [15:0]        u_t_r;
  logic               u_dz_r, u_bz_r;

  always_comb begin
    u_prod   = 60'(p_sq_r) * 60'(P_K1);
    u_x1_nxt = u_prod[59:16];
    u_x2_nxt = 31'(p_m_r >>> 16);
  end

  // output stage
  logic signed [44:0] r_s;
  logic signed [45:0] r_p;
  logic [17:0]        r_sat;
  logic signed [15:0] out_t_nxt, out_t_r;
  logic [17:0]        out_p_nxt, out_p_r;
  logic               out_f_nxt, out_f_r;

  always_comb begin
    r_s = 45'($signed({1'b0, u_x1_r})) + 45'(u_x2_r) + P_K3;
    r_p = 46'($signed({1'b0, u_p_r})) + 46'(r_s >>> 4);
    if (r_p[45]) begin
      r_sat = '0;
    end else if (r_p > 46'($signed({1'b0, P_MAX}))) begin
      r_sat = P_MAX;
    end else begin
      r_sat = r_p[17:0];
    end
    out_f_nxt = u_dz_r | u_bz_r;
    out_t_nxt = u_dz_r ? 16'sd0 : $signed(u_t_r);
    out_p_nxt = out_f_nxt ? 18'd0 : r_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      f_vld_r     <= 1'b0;
      g_vld_r     <= 1'b0;
      h_vld_r     <= 1'b0;
      i_vld_r     <= 1'b0;
      j_vld_r     <= 1'b0;
      k_vld_r     <= 1'b0;
      l_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      n_vld_r     <= 1'b0;
      o_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      u_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= acc && in_operation == OP_COMP;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      e_vld_r     <= div1_vld;
      f_vld_r     <= e_vld_r;
      g_vld_r     <= f_vld_r;
      h_vld_r     <= g_vld_r;
      i_vld_r     <= h_vld_r;
      j_vld_r     <= i_vld_r;
      k_vld_r     <= j_vld_r;
      l_vld_r     <= k_vld_r;
      m_vld_r     <= l_vld_r;
      n_vld_r     <= m_vld_r;
      o_vld_r     <= div2_vld;
      p_vld_r     <= o_vld_r;
      u_vld_r     <= p_vld_r;
      out_valid_r <= u_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_ut_r   <= in_raw_temperature;
    a_up_r   <= in_raw_pressure;
    a_ac5_r  <= cal_r[CAL_AC5];
    a_ac6_r  <= cal_r[CAL_AC6];
    a_mc_r   <= cal_r[CAL_MC];
    a_md_r   <= cal_r[CAL_MD];
    a_late_r <= late_now;

    b_prod_r <= b_prod_nxt;
    b_mc_r   <= a_mc_r;
    b_md_r   <= a_md_r;
    b_up_r   <= a_up_r;
    b_late_r <= a_late_r;

    c_x1_r   <= c_x1_nxt;
    c_div_r  <= c_div_nxt;
    c_mc_r   <= b_mc_r;
    c_up_r   <= b_up_r;
    c_late_r <= b_late_r;

    d_dvd_r  <= d_dvd_nxt;
    d_dvs_r  <= d_dvs_nxt;
    d_x1_r   <= c_x1_r;
    d_neg_r  <= c_mc_r[15] ^ c_div_r[19];
    d_dz_r   <= (c_div_r == '0);
    d_up_r   <= c_up_r;
    d_late_r <= c_late_r;

    e_b5_r   <= e_b5_nxt;
    e_dz_r   <= s1o.dz;
    e_up_r   <= s1o.up;
    e_late_r <= s1o.late;

    f_t_r    <= f_t_nxt;
    f_b6_r   <= f_b6_nxt;
    f_dz_r   <= e_dz_r;
    f_up_r   <= e_up_r;
    f_late_r <= e_late_r;

    g_sq_r   <= g_sq_nxt;
    g_m2_r   <= g_m2_nxt;
    g_m3_r   <= g_m3_nxt;
    g_t_r    <= f_t_r;
    g_dz_r   <= f_dz_r;
    g_up_r   <= f_up_r;
    g_late_r <= f_late_r;

    h_b2lo_r <= h_b2lo_nxt;
    h_b2hi_r <= h_b2hi_nxt;
    h_b1lo_r <= h_b1lo_nxt;
    h_b1hi_r <= h_b1hi_nxt;
    h_x2a_r  <= h_x2a_nxt;
    h_x1b_r  <= h_x1b_nxt;
    h_t_r    <= g_t_r;
    h_dz_r   <= g_dz_r;
    h_up_r   <= g_up_r;
    h_late_r <= g_late_r;

    i_b2sq_r <= i_b2sq_nxt;
    i_b1sq_r <= i_b1sq_nxt;
    i_x2a_r  <= h_x2a_r;
    i_x1b_r  <= h_x1b_r;
    i_t_r    <= h_t_r;
    i_dz_r   <= h_dz_r;
    i_up_r   <= h_up_r;
    i_late_r <= h_late_r;

    j_x3a_r  <= j_x3a_nxt;
    j_s_r    <= j_s_nxt;
    j_t_r    <= i_t_r;
    j_dz_r   <= i_dz_r;
    j_up_r   <= i_up_r;
    j_late_r <= i_late_r;

    k_v_r    <= k_v_nxt;
    k_lo_r   <= k_lo_nxt;
    k_t_r    <= j_t_r;
    k_dz_r   <= j_dz_r;
    k_up_r   <= j_up_r;
    k_late_r <= j_late_r;

    l_b3_r   <= l_b3_nxt;
    l_b4_r   <= l_b4_nxt;
    l_t_r    <= k_t_r;
    l_dz_r   <= k_dz_r;
    l_up_r   <= k_up_r;

    m_diff_r <= m_diff_nxt;
    m_b4_r   <= l_b4_r;
    m_t_r    <= l_t_r;
    m_dz_r   <= l_dz_r;

    n_b7_r   <= n_b7_nxt;
    n_b4_r   <= m_b4_r;
    n_t_r    <= m_t_r;
    n_dz_r   <= m_dz_r;

    o_p_r    <= o_p_nxt;
    o_t_r    <= s2o.t;
    o_dz_r   <= s2o.dz;
    o_bz_r   <= s2o.bz;

    p_sq_r   <= p_sq_nxt;
    p_m_r    <= p_m_nxt;
    p_p_r    <= o_p_r;
    p_t_r    <= o_t_r;
    p_dz_r   <= o_dz_r;
    p_bz_r   <= o_bz_r;

    u_x1_r   <= u_x1_nxt;
    u_x2_r   <= u_x2_nxt;
    u_p_r    <= p_p_r;
    u_t_r    <= p_t_r;
    u_dz_r   <= p_dz_r;
    u_bz_r   <= p_bz_r;

    out_t_r  <= out_t_nxt;
    out_p_r  <= out_p_nxt;
    out_f_r  <= out_f_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_t_r;
  assign out_pressure_pa        = out_p_r;
  assign out_divide_fault       = out_f_r;

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcsc_pkg::*;

  localparam logic [CAL_IDX_W-1:0] CAL_MB = 4'd8;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1760;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               fault;
  } reading_t;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [15:0] val;
    logic [15:0] ut;
    logic [18:0] up;
    bit          typed;
    reading_t    res;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic [3:0]         in_calib_index;
  logic [15:0]        in_calib_value;
  logic [15:0]        in_raw_temperature;
  logic [18:0]        in_raw_pressure;
  logic               cfg_wr_en;
  logic [1:0]         cfg_wr_data;
  logic               out_valid;
  logic signed [15:0] out_temperature_tenths;
  logic [17:0]        out_pressure_pa;
  logic               out_divide_fault;

  logic [15:0] cal_words [CAL_WORDS];
  logic [1:0]  oss_mode;
  reading_t    readings_due[$];
  int          error_count;
  int          idle_cycles;
  int          burst_left;

  barometric_sensor_compensation_unit i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_calib_index         (in_calib_index),
    .in_calib_value         (in_calib_value),
    .in_raw_temperature     (in_raw_temperature),
    .in_raw_pressure        (in_raw_pressure),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .out_valid              (out_valid),
    .out_temperature_tenths (out_temperature_tenths),
    .out_pressure_pa        (out_pressure_pa),
    .out_divide_fault       (out_divide_fault)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sword(input logic [15:0] w);
    return longint'($signed(w));
  endfunction

  function automatic longint uword(input logic [15:0] w);
    return longint'({48'd0, w});
  endfunction

  function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [18:0] up_raw);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, x1, x2, x3, dvs, b5, b6, t, b3, p, sq;
    logic [63:0] prod;
    logic [31:0] b4, b7, pu, diff, twice;
    reading_t r;
    ac1 = sword(cal_words[CAL_AC1]);
    ac2 = sword(cal_words[CAL_AC2]);
    ac3 = sword(cal_words[CAL_AC3]);
    ac4 = uword(cal_words[CAL_AC4]);
    ac5 = uword(cal_words[CAL_AC5]);
    ac6 = uword(cal_words[CAL_AC6]);
    b1  = sword(cal_words[CAL_B1]);
    b2  = sword(cal_words[CAL_B2]);
    mc  = sword(cal_words[CAL_MC]);
    md  = sword(cal_words[CAL_MD]);
    r = '0;
    ut = longint'({48'd0, ut_raw});
    x1 = ((ut - ac6) * ac5) >>> 15;
    dvs = x1 + md;
    if (dvs == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / dvs;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    if (t < longint'(T_MIN)) t = longint'(T_MIN);
    if (t > longint'(T_MAX)) t = longint'(T_MAX);
    r.temp = 16'(t);
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_mode) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    prod = 64'(ac4) * {32'd0, 32'(x3 + 32768)};
    b4 = prod[31:0] >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    diff = {13'd0, up_raw} - 32'(b3);
    prod = {32'd0, diff} * {32'd0, 32'(50000 >> oss_mode)};
    b7 = prod[31:0];
    if (b7 < 32'h8000_0000) begin
      twice = b7 << 1;
      pu = twice / b4;
    end else begin
      pu = (b7 / b4) << 1;
    end
    p = longint'({32'd0, pu});
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (longint'(-7357) * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (p < 0) p = 0;
    if (p > longint'(P_MAX)) p = longint'(P_MAX);
    r.pres = 18'(p);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = readings_due.pop_front();
        if (out_temperature_tenths !== want.temp)
          report_mismatch("temperature_tenths", out_temperature_tenths, want.temp);
        if (out_pressure_pa !== want.pres)
          report_mismatch("pressure_pa", out_pressure_pa, want.pres);
        if (out_divide_fault !== want.fault)
          report_mismatch("divide_fault", out_divide_fault, want.fault);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(input logic op, input logic [3:0] idx, input logic [15:0] val,
                      input logic [15:0] ut, input logic [18:0] up,
                      input bit typed, input reading_t typed_res);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_operation = op;
    in_calib_index = idx;
    in_calib_value = val;
    in_raw_temperature = ut;
    in_raw_pressure = up;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (op == OP_CAL) begin
      if (idx < CAL_WORDS) cal_words[idx] = val;
    end else if (typed) begin
      readings_due.push_back(typed_res);
    end else begin
      readings_due.push_back(compensate(ut, up));
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic set_oss(input logic [1:0] mode);
    @(negedge clk);
    start = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    oss_mode = mode;
  endtask

  function automatic logic [15:0] nominal_word(input int i);
    case (i)
      0: return 16'd408;
      1: return 16'(-72);
      2: return 16'(-14383);
      3: return 16'd32741;
      4: return 16'd32757;
      5: return 16'd23153;
      6: return 16'd6190;
      7: return 16'd4;
      8: return 16'h8000;
      9: return 16'(-8711);
      default: return 16'd2868;
    endcase
  endfunction

  initial begin
    dir_row_t rows[$];
    logic [1:0] phases[6];
    reading_t none;
    logic [3:0] idx;
    logic [15:0] val;
    none = '0;
    phases = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd0};
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_CAL;
    in_calib_index = '0;
    in_calib_value = '0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    oss_mode = '0;
    error_count = 0;
    burst_left = 0;
    foreach (cal_words[i]) cal_words[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_oss(2'd0);
    rows = '{
      '{OP_CAL, CAL_AC1, 16'd408, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_AC2, 16'(-72), 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_AC3, 16'(-14383), 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_AC4, 16'd32741, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_AC5, 16'd32757, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_AC6, 16'd23153, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_B1, 16'd6190, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_B2, 16'd4, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_MB, 16'h8000, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_MC, 16'(-8711), 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_MD, 16'd2868, 16'd0, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'd27898, 19'd23843, 1'b1, '{16'sd150, 18'd69964, 1'b0}},
      '{OP_COMP, 4'd15, 16'hFFFF, 16'd0, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'hFFFF, 19'h7FFFF, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'hFFFF, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'd0, 19'h7FFFF, 1'b0, none},
      // index above ten is dropped
      '{OP_CAL, 4'd15, 16'd0, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, 4'd11, 16'hFFFF, 16'd0, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'd27898, 19'd23843, 1'b1, '{16'sd150, 18'd69964, 1'b0}},
      // zero temperature divisor
      '{OP_CAL, CAL_AC5, 16'd0, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_MD, 16'd0, 16'd0, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'd27898, 19'd23843, 1'b1, '{16'sd0, 18'd0, 1'b1}},
      '{OP_CAL, CAL_AC5, 16'd32757, 16'd0, 19'd0, 1'b0, none},
      '{OP_CAL, CAL_MD, 16'd2868, 16'd0, 19'd0, 1'b0, none},
      // zero pressure divisor
      '{OP_CAL, CAL_AC4, 16'd0, 16'd0, 19'd0, 1'b0, none},
      '{OP_COMP, 4'd0, 16'd0, 16'd27898, 19'd23843, 1'b0, none},
      '{OP_CAL, CAL_AC4, 16'd32741, 16'd0, 19'd0, 1'b0, none}
    };
    foreach (rows[i])
      send(rows[i].op, rows[i].idx, rows[i].val, rows[i].ut, rows[i].up,
           rows[i].typed, rows[i].res);

    foreach (phases[ph]) begin
      set_oss(phases[ph]);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        if ($urandom_range(9) == 0) begin
          idx = 4'($urandom_range(15));
          case ($urandom_range(3))
            0: val = 16'($urandom);
            1: val = (idx < CAL_WORDS) ? nominal_word(idx) : 16'($urandom);
            default: val = (idx < CAL_WORDS) ?
                nominal_word(idx) + 16'($urandom_range(64)) - 16'd32 : 16'($urandom);
          endcase
          send(OP_CAL, idx, val, 16'($urandom), 19'($urandom), 1'b0, none);
        end else begin
          send(OP_COMP, 4'($urandom), 16'($urandom),
               ($urandom_range(1) == 0) ? 16'($urandom) : 16'(27898 + $urandom_range(8000) - 4000),
               ($urandom_range(1) == 0) ? 19'($urandom) :
                   19'((23843 << phases[ph]) + $urandom_range(16000) - 8000),
               1'b0, none);
        end
      end
      // restore sane calibration for the next phase
      for (int i = 0; i < CAL_WORDS; i++)
        send(OP_CAL, 4'(i), nominal_word(i), 16'd0, 19'd0, 1'b0, none);
    end

    @(negedge clk);
    start = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
